// ===== design/fvg_pkg.sv =====
package fvg_pkg;

	localparam int unsigned SECTOR_BYTES = 512;
	localparam int unsigned SECT_SHIFT   = $clog2(SECTOR_BYTES);
	localparam int unsigned DIV_CELLS    = 32;

	localparam logic [31:0] FAT12_LIMIT = 32'd4085;
	localparam logic [31:0] FAT16_LIMIT = 32'd65525;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_SIZE = 2'd1;
	localparam logic [1:0] ST_ZERO_SPC = 2'd2;

	localparam logic [1:0] KIND_FAT12   = 2'd0;
	localparam logic [1:0] KIND_FAT16   = 2'd1;
	localparam logic [1:0] KIND_FAT32   = 2'd2;
	localparam logic [1:0] KIND_INVALID = 2'd3;

	typedef struct packed {
		logic [31:0] start_lba;
		logic [15:0] bytes_per_sector;
		logic [7:0]  sectors_per_cluster;
		logic [15:0] reserved_sectors;
		logic [7:0]  fat_copies;
		logic [15:0] root_entries;
		logic [15:0] total_sectors_short;
		logic [31:0] total_sectors_long;
		logic [15:0] fat_sectors_short;
		logic [31:0] fat_sectors_long;
	} item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [1:0]  fat_kind;
		logic [31:0] total_sectors;
		logic [31:0] fat_size;
		logic [12:0] root_dir_sectors;
		logic [31:0] fat_start;
		logic [31:0] root_start;
		logic [31:0] data_start;
		logic [31:0] data_sectors;
		logic [31:0] cluster_count;
	} result_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] total;
		logic [31:0] fsz;
		logic [12:0] rds;
		logic [31:0] fstart;
		logic [31:0] rstart;
		logic [31:0] dstart;
		logic [31:0] dsec;
	} geo_t;

	// one beat through the divider row: carried geometry, remainder, quotient/dividend shifter, divisor
	typedef struct packed {
		geo_t        geo;
		logic [8:0]  rem;
		logic [31:0] quo;
		logic [7:0]  divisor;
	} div_word_t;

endpackage

// ===== design/fvg_front.sv =====
module fvg_front import fvg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      up_valid,
	output logic      up_ready,
	input  item_t     up_item,
	output logic      dn_valid,
	input  logic      dn_ready,
	output div_word_t dn_word
);

	logic        valid_s1, valid_s2;
	logic        ready_s1, ready_s2;
	logic [1:0]  status_s1;
	logic [31:0] total_s1, fsz_s1, fstart_s1, prod_s1;
	logic [15:0] res_s1;
	logic [12:0] rds_s1;
	logic [7:0]  spc_s1;
	div_word_t   word_s2;

	logic [1:0]  status_c;
	logic [31:0] total_c, fsz_c;
	logic [21:0] rds_sum_c;
	logic [31:0] prod_c;
	logic [31:0] rstart_c, fat_area_c;

	assign ready_s2 = !valid_s2 || dn_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign up_ready = ready_s1;

	always_comb begin
		priority if (up_item.bytes_per_sector != 16'(SECTOR_BYTES)) begin
			status_c = ST_BAD_SIZE;
		end else if (up_item.sectors_per_cluster == 8'd0) begin
			status_c = ST_ZERO_SPC;
		end else begin
			status_c = ST_OK;
		end
		total_c = (up_item.total_sectors_short != 16'd0) ?
			{16'd0, up_item.total_sectors_short} : up_item.total_sectors_long;
		fsz_c = (up_item.fat_sectors_short != 16'd0) ?
			{16'd0, up_item.fat_sectors_short} : up_item.fat_sectors_long;
		rds_sum_c = {1'b0, up_item.root_entries, 5'd0} + 22'(SECTOR_BYTES - 1);
		prod_c = {24'd0, up_item.fat_copies} * fsz_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && up_valid) begin
			status_s1 <= status_c;
			total_s1  <= total_c;
			fsz_s1    <= fsz_c;
			rds_s1    <= 13'(rds_sum_c >> SECT_SHIFT);
			fstart_s1 <= up_item.start_lba + {16'd0, up_item.reserved_sectors};
			res_s1    <= up_item.reserved_sectors;
			prod_s1   <= prod_c;
			spc_s1    <= up_item.sectors_per_cluster;
		end
	end

	assign rstart_c   = fstart_s1 + prod_s1;
	assign fat_area_c = {16'd0, res_s1} + prod_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			word_s2.geo.status <= status_s1;
			word_s2.geo.total  <= total_s1;
			word_s2.geo.fsz    <= fsz_s1;
			word_s2.geo.rds    <= rds_s1;
			word_s2.geo.fstart <= fstart_s1;
			word_s2.geo.rstart <= rstart_c;
			word_s2.geo.dstart <= rstart_c + {19'd0, rds_s1};
			word_s2.geo.dsec   <= total_s1 - (fat_area_c + {19'd0, rds_s1});
			word_s2.rem        <= 9'd0;
			word_s2.quo        <= total_s1 - (fat_area_c + {19'd0, rds_s1});
			word_s2.divisor    <= spc_s1;
		end
	end

	assign dn_valid = valid_s2;
	assign dn_word  = word_s2;

endmodule

// ===== design/fvg_div_cell.sv =====
module fvg_div_cell import fvg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      up_valid,
	output logic      up_ready,
	input  div_word_t up_word,
	output logic      dn_valid,
	input  logic      dn_ready,
	output div_word_t dn_word
);

	logic      valid_q;
	div_word_t word_q;
	div_word_t next_c;
	logic [8:0] shifted_c;
	logic       ge_c;

	assign up_ready = !valid_q || dn_ready;

	// one restoring step: bring in the next dividend bit, subtract if it fits
	always_comb begin
		shifted_c = {up_word.rem[7:0], up_word.quo[31]};
		ge_c      = shifted_c >= {1'b0, up_word.divisor};
		next_c         = up_word;
		next_c.rem     = ge_c ? (shifted_c - {1'b0, up_word.divisor}) : shifted_c;
		next_c.quo     = {up_word.quo[30:0], ge_c};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			word_q <= next_c;
		end
	end

	assign dn_valid = valid_q;
	assign dn_word  = word_q;

endmodule

// ===== design/fat_volume_geometry_unit.sv =====
// FAT volume geometry: one boot-sector beat in, one result beat out, one beat per cycle
// sustained when nothing stalls. Two front stages pick the sizes, form copies*fat_size
// and the layout sums; a row of 32 divider cells then takes one quotient bit each to
// give the cluster count, and an output register classifies the FAT type and zeroes
// every field but status on error. Every stage holds its own valid bit, so bubbles
// close up and the block keeps taking beats while a finished result waits under stall,
// until every stage is full.
module fat_volume_geometry_unit import fvg_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	logic      front_ready;
	logic      cell_valid [DIV_CELLS+1];
	logic      cell_ready [DIV_CELLS+1];
	div_word_t cell_word  [DIV_CELLS+1];

	logic      res_valid_q;
	result_t   res_q;
	result_t   res_c;
	geo_t      g;
	logic      out_ready;

	assign item_stall = !front_ready;

	fvg_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (item_valid),
		.up_ready (front_ready),
		.up_item  (item),
		.dn_valid (cell_valid[0]),
		.dn_ready (cell_ready[0]),
		.dn_word  (cell_word[0])
	);

	for (genvar i = 0; i < DIV_CELLS; i++) begin : g_cell
		fvg_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (cell_valid[i]),
			.up_ready (cell_ready[i]),
			.up_word  (cell_word[i]),
			.dn_valid (cell_valid[i+1]),
			.dn_ready (cell_ready[i+1]),
			.dn_word  (cell_word[i+1])
		);
	end

	assign out_ready             = !res_valid_q || !result_stall;
	assign cell_ready[DIV_CELLS] = out_ready;
	assign g                     = cell_word[DIV_CELLS].geo;

	always_comb begin
		res_c = '0;
		res_c.status = g.status;
		if (g.status == ST_OK) begin
			priority if (cell_word[DIV_CELLS].quo < FAT12_LIMIT) begin
				res_c.fat_kind = KIND_FAT12;
			end else if (cell_word[DIV_CELLS].quo < FAT16_LIMIT) begin
				res_c.fat_kind = KIND_FAT16;
			end else begin
				res_c.fat_kind = KIND_FAT32;
			end
			res_c.total_sectors    = g.total;
			res_c.fat_size         = g.fsz;
			res_c.root_dir_sectors = g.rds;
			res_c.fat_start        = g.fstart;
			res_c.root_start       = g.rstart;
			res_c.data_start       = g.dstart;
			res_c.data_sectors     = g.dsec;
			res_c.cluster_count    = cell_word[DIV_CELLS].quo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_ready) begin
			res_valid_q <= cell_valid[DIV_CELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && cell_valid[DIV_CELLS]) begin
			res_q <= res_c;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

// ===== design/fvg_checker.sv =====
module fvg_checker import fvg_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result beat dropped or changed under stall");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status != ST_OK |->
			result.fat_kind == KIND_FAT12 && result.total_sectors == 32'd0 &&
			result.fat_size == 32'd0 && result.root_dir_sectors == 13'd0 &&
			result.fat_start == 32'd0 && result.root_start == 32'd0 &&
			result.data_start == 32'd0 && result.data_sectors == 32'd0 &&
			result.cluster_count == 32'd0)
		else $error("error beat carries nonzero fields");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status == ST_OK |->
			(result.fat_kind == KIND_FAT12) == (result.cluster_count < FAT12_LIMIT) &&
			(result.fat_kind == KIND_FAT32) == (result.cluster_count >= FAT16_LIMIT))
		else $error("FAT type disagrees with cluster count");

	a_layout: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status == ST_OK |->
			result.data_start == result.root_start + {19'd0, result.root_dir_sectors})
		else $error("data start does not follow root directory");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.status == ST_OK || result.status == ST_BAD_SIZE ||
			result.status == ST_ZERO_SPC)
		else $error("status code out of range");

endmodule

bind fat_volume_geometry_unit fvg_checker u_fvg_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

// ===== tb/testbench.sv =====
module testbench;
	import fvg_pkg::*;

	localparam int unsigned RANDOM_VOLUMES = 1330;
	localparam int unsigned QUIET_FROM = 600;
	localparam int unsigned QUIET_TO = 800;
	localparam int unsigned HOLD_AT = 300;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned PAUSE_AT = 1000;
	localparam int unsigned DRAIN_CYCLES = 60;
	localparam int unsigned MAX_REPORTS = 50;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_stall;
	item_t   item = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	item_t       pending_volumes[$];
	result_t     expected_layouts[$];
	int unsigned volumes_accepted = 0;
	int unsigned layouts_checked = 0;
	int unsigned mismatch_count = 0;
	int unsigned hold_left = 0;
	bit          hold_done = 1'b0;
	int unsigned n_fat12 = 0, n_fat16 = 0, n_fat32 = 0, n_bad_size = 0, n_zero_spc = 0;

	fat_volume_geometry_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic logic [31:0] root_sectors_of(logic [15:0] entries);
		return ({16'h0, entries} * 32'd32 + 32'(SECTOR_BYTES - 1)) / 32'(SECTOR_BYTES);
	endfunction

	function automatic result_t predict_geometry(item_t v);
		result_t     r;
		logic [31:0] rds;
		logic [31:0] fat_area;
		r = '0;
		if (v.bytes_per_sector != 16'(SECTOR_BYTES)) begin
			r.status = ST_BAD_SIZE;
		end else if (v.sectors_per_cluster == 8'd0) begin
			r.status = ST_ZERO_SPC;
		end else begin
			r.status = ST_OK;
			r.total_sectors = (v.total_sectors_short != 16'd0) ?
				{16'h0, v.total_sectors_short} : v.total_sectors_long;
			r.fat_size = (v.fat_sectors_short != 16'd0) ?
				{16'h0, v.fat_sectors_short} : v.fat_sectors_long;
			rds = root_sectors_of(v.root_entries);
			fat_area = {24'h0, v.fat_copies} * r.fat_size;
			r.root_dir_sectors = rds[12:0];
			r.fat_start = v.start_lba + {16'h0, v.reserved_sectors};
			r.root_start = r.fat_start + fat_area;
			r.data_start = r.root_start + rds;
			r.data_sectors = r.total_sectors - ({16'h0, v.reserved_sectors} + fat_area + rds);
			r.cluster_count = r.data_sectors / {24'h0, v.sectors_per_cluster};
			if (r.cluster_count < FAT12_LIMIT)
				r.fat_kind = KIND_FAT12;
			else if (r.cluster_count < FAT16_LIMIT)
				r.fat_kind = KIND_FAT16;
			else
				r.fat_kind = KIND_FAT32;
		end
		return r;
	endfunction

	// plain FAT16 volume, tweaked by the directed cases
	function automatic item_t base_volume();
		item_t v;
		v.start_lba = 32'd2048;
		v.bytes_per_sector = 16'(SECTOR_BYTES);
		v.sectors_per_cluster = 8'd4;
		v.reserved_sectors = 16'd4;
		v.fat_copies = 8'd2;
		v.root_entries = 16'd512;
		v.total_sectors_short = 16'd0;
		v.total_sectors_long = 32'd204800;
		v.fat_sectors_short = 16'd200;
		v.fat_sectors_long = 32'd0;
		return v;
	endfunction

	// bare volume: layout starts at zero, so the cluster count is total / spc
	function automatic item_t bare_volume(logic [7:0] spc, logic [31:0] total);
		item_t v;
		v = '0;
		v.bytes_per_sector = 16'(SECTOR_BYTES);
		v.sectors_per_cluster = spc;
		v.total_sectors_long = total;
		return v;
	endfunction

	function automatic item_t random_volume();
		item_t       v;
		logic [31:0] clusters;
		logic [31:0] fsz;
		logic [31:0] total;
		v = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		if ($urandom_range(99) < 15) begin
			if ($urandom_range(1))
				v.bytes_per_sector = 16'(SECTOR_BYTES);
			if ($urandom_range(3) == 0)
				v.sectors_per_cluster = 8'd0;
			return v;
		end
		v.bytes_per_sector = 16'(SECTOR_BYTES);
		v.sectors_per_cluster = ($urandom_range(3) == 0) ? 8'($urandom_range(1, 255)) :
			8'(1 << $urandom_range(7));
		if ($urandom_range(1))
			v.reserved_sectors = 16'($urandom_range(1, 64));
		v.fat_copies = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(1, 2));
		case ($urandom_range(3))
			0: v.root_entries = 16'd0;
			1: v.root_entries = 16'd512;
			default: ;
		endcase
		case ($urandom_range(2))
			0: clusters = $urandom_range(1, 4200);
			1: clusters = $urandom_range(3900, 70000);
			default: clusters = $urandom_range(65000, 2000000);
		endcase
		fsz = clusters / 128 + $urandom_range(1, 3);
		if (fsz < 32'd65536 && $urandom_range(1)) begin
			v.fat_sectors_short = fsz[15:0];
		end else begin
			v.fat_sectors_short = 16'd0;
			v.fat_sectors_long = fsz;
		end
		total = {16'h0, v.reserved_sectors} + {24'h0, v.fat_copies} * fsz +
			root_sectors_of(v.root_entries) + clusters * {24'h0, v.sectors_per_cluster} +
			$urandom_range(0, v.sectors_per_cluster - 1);
		if (total < 32'd65536 && $urandom_range(1)) begin
			v.total_sectors_short = total[15:0];
		end else begin
			v.total_sectors_short = 16'd0;
			v.total_sectors_long = total;
		end
		return v;
	endfunction

	task automatic fill_directed();
		item_t v;
		pending_volumes.push_back(base_volume());
		v = base_volume(); v.bytes_per_sector = 16'd0; pending_volumes.push_back(v);
		v = base_volume(); v.bytes_per_sector = 16'hFFFF; pending_volumes.push_back(v);
		v = base_volume(); v.bytes_per_sector = 16'd4096; pending_volumes.push_back(v);
		// sector size is checked ahead of the cluster size
		v = base_volume(); v.bytes_per_sector = 16'd513; v.sectors_per_cluster = 8'd0;
		pending_volumes.push_back(v);
		v = base_volume(); v.sectors_per_cluster = 8'd0; pending_volumes.push_back(v);
		v = base_volume(); v.sectors_per_cluster = 8'd255; pending_volumes.push_back(v);
		pending_volumes.push_back(bare_volume(8'd1, 32'd4084));
		pending_volumes.push_back(bare_volume(8'd2, 32'd8170));
		pending_volumes.push_back(bare_volume(8'd1, 32'd65524));
		pending_volumes.push_back(bare_volume(8'd4, 32'd262100));
		pending_volumes.push_back(bare_volume(8'd1, 32'd0));
		v = base_volume(); v.total_sectors_short = 16'hFFFF; v.total_sectors_long = 32'hDEADBEEF;
		pending_volumes.push_back(v);
		v = base_volume(); v.fat_sectors_short = 16'd0; v.fat_sectors_long = 32'hFFFFFFFF;
		v.fat_copies = 8'hFF; pending_volumes.push_back(v);
		// data region below zero wraps
		v = base_volume(); v.total_sectors_long = 32'd100; v.reserved_sectors = 16'd200;
		pending_volumes.push_back(v);
		v = '1; v.bytes_per_sector = 16'(SECTOR_BYTES); pending_volumes.push_back(v);
		v = base_volume(); v.start_lba = 32'hFFFFFF00; pending_volumes.push_back(v);
		v = base_volume(); v.root_entries = 16'd1; pending_volumes.push_back(v);
		v = base_volume(); v.root_entries = 16'd16; pending_volumes.push_back(v);
		v = base_volume(); v.root_entries = 16'd17; pending_volumes.push_back(v);
		v = base_volume(); v.root_entries = 16'd0; v.fat_sectors_short = 16'd0;
		v.fat_sectors_long = 32'd8000; v.total_sectors_long = 32'd16777216;
		v.sectors_per_cluster = 8'd8; v.reserved_sectors = 16'd32; pending_volumes.push_back(v);
	endtask

	initial begin
		fill_directed();
		repeat (RANDOM_VOLUMES) pending_volumes.push_back(random_volume());
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_volumes.size() != 0 || item_valid) @(posedge clk);
		while (expected_layouts.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d volumes checked: %0d FAT12, %0d FAT16, %0d FAT32, %0d bad sector size,",
			layouts_checked, n_fat12, n_fat16, n_fat32, n_bad_size);
		$display("%0d zero cluster size; long receiver hold-off and a full drain pause included",
			n_zero_spc);
		if (mismatch_count == 0 && expected_layouts.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#(12 * 400000);
		$display("Test completed with failures");
		$finish;
	end

	// sender
	always @(posedge clk) begin
		result_t layout;
		bit      idle;
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				layout = predict_geometry(item);
				expected_layouts.push_back(layout);
				volumes_accepted++;
				if (layout.status == ST_BAD_SIZE)
					n_bad_size++;
				else if (layout.status == ST_ZERO_SPC)
					n_zero_spc++;
				else if (layout.fat_kind == KIND_FAT12)
					n_fat12++;
				else if (layout.fat_kind == KIND_FAT16)
					n_fat16++;
				else
					n_fat32++;
			end
			if (!(item_valid && item_stall)) begin
				idle = (volumes_accepted < QUIET_FROM || volumes_accepted >= QUIET_TO) &&
					$urandom_range(99) < 17;
				if (volumes_accepted == PAUSE_AT && expected_layouts.size() != 0)
					idle = 1'b1;
				if (!idle && pending_volumes.size() != 0) begin
					item <= pending_volumes.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			mismatch_count++;
			if (mismatch_count <= MAX_REPORTS)
				$display("%0t: %s expected %h got %h", $time, name, want, got);
		end
	endtask

	// receiver
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (expected_layouts.size() == 0) begin
					mismatch_count++;
					$display("%0t: unexpected result beat, expected none got %h", $time, result);
				end else begin
					want = expected_layouts.pop_front();
					check_field("status", want.status, result.status);
					check_field("fat_kind", want.fat_kind, result.fat_kind);
					check_field("total_sectors", want.total_sectors, result.total_sectors);
					check_field("fat_size", want.fat_size, result.fat_size);
					check_field("root_dir_sectors", want.root_dir_sectors,
						result.root_dir_sectors);
					check_field("fat_start", want.fat_start, result.fat_start);
					check_field("root_start", want.root_start, result.root_start);
					check_field("data_start", want.data_start, result.data_start);
					check_field("data_sectors", want.data_sectors, result.data_sectors);
					check_field("cluster_count", want.cluster_count, result.cluster_count);
				end
				layouts_checked++;
			end
			if (hold_left != 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (!hold_done && layouts_checked == HOLD_AT) begin
				// long hold-off so the pipe backs up into the input
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				result_stall <= 1'b1;
			end else if (layouts_checked >= QUIET_FROM && layouts_checked < QUIET_TO) begin
				result_stall <= 1'b0;
			end else begin
				result_stall <= ($urandom_range(99) < 17);
			end
		end
	end

endmodule
